[hdl/escmk_pkg.sv]
// Shared constants, types and helpers for the encoder step counter with mode keys.
`default_nettype none
package escmk_pkg;

   localparam int MODE_W     = 8;
   localparam int BTN_W      = 8;
   localparam int ENC_W      = 4;
   localparam int STABLE_W   = 3;
   localparam int HIST_W     = 6;

   localparam int COUNT_SPAN_DEF = 1024;

   // sample kinds carried on req_tuser
   localparam logic FUNC_BUTTON  = 1'b0;
   localparam logic FUNC_ENCODER = 1'b1;

   // encoder_bits layout
   localparam int ENC1_LINE = 3;
   localparam int ENC1_DIR  = 2;
   localparam int ENC2_LINE = 1;
   localparam int ENC2_DIR  = 0;

   localparam logic [HIST_W-1:0]   STEP_PATTERN  = 6'h3E;
   localparam logic [STABLE_W-1:0] STABLE_TARGET = 3'd6;
   localparam logic [STABLE_W-1:0] STABLE_MAX    = 3'd7;
   localparam logic [MODE_W-1:0]   MODE_RESET    = 8'h01;

   // input beat layout
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_BTN_LSB = 0;
   localparam int REQ_ENC_LSB = BTN_W;

   typedef struct packed {
      logic [MODE_W-1:0] mode_now;
      logic              mode_ok;
   } status_type;

   // zero or exactly one bit set
   function automatic logic mode_is_ok(input logic [MODE_W-1:0] m);
      return (m & (m - MODE_W'(1))) == '0;
   endfunction

endpackage
`default_nettype wire

[hdl/escmk_update.sv]
// State registers and single-pass next-state logic for one sample.
`default_nettype none
module escmk_update #(
   parameter int COUNT_SPAN = escmk_pkg::COUNT_SPAN_DEF,
   localparam int CNT_W     = $clog2(COUNT_SPAN)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic                          func,
   input  wire logic [escmk_pkg::BTN_W-1:0]   buttons,
   input  wire logic [escmk_pkg::ENC_W-1:0]   encoder_bits,
   output escmk_pkg::status_type              status,
   output logic      [CNT_W-1:0]              count_value
);
   import escmk_pkg::*;

   localparam int SUM_W = CNT_W + 2;
   localparam logic signed [SUM_W-1:0] SPAN_S = SUM_W'(COUNT_SPAN);
   localparam logic signed [SUM_W-1:0] TOP_S  = SUM_W'(COUNT_SPAN - 1);

   logic [BTN_W-1:0]    last_buttons_ff, last_buttons_in;
   logic [STABLE_W-1:0] stable_count_ff, stable_count_in;
   logic [MODE_W-1:0]   mode_bits_ff, mode_bits_in;
   logic [HIST_W-1:0]   first_history_ff, first_history_in;
   logic [HIST_W-1:0]   second_history_ff, second_history_in;
   logic [CNT_W-1:0]    counter_ff, counter_in;

   logic                    is_encoder;
   logic                    count_enable;
   logic signed [SUM_W-1:0] mode_ext;
   logic signed [SUM_W-1:0] step1, step2;
   logic signed [SUM_W-1:0] sum_raw, sum_wrap;

   assign is_encoder = (func == FUNC_ENCODER);

   // button debounce
   always_comb begin
      last_buttons_in = last_buttons_ff;
      stable_count_in = stable_count_ff;
      mode_bits_in    = mode_bits_ff;
      if (!is_encoder) begin
         if (buttons != last_buttons_ff) begin
            last_buttons_in = buttons;
            stable_count_in = '0;
         end else if (stable_count_ff != STABLE_MAX) begin
            stable_count_in = stable_count_ff + STABLE_W'(1);
         end
         if (stable_count_in == STABLE_TARGET) begin
            mode_bits_in = mode_bits_ff ^ buttons;
         end
      end
   end

   // encoder histories and counter step
   always_comb begin
      first_history_in  = first_history_ff;
      second_history_in = second_history_ff;
      if (is_encoder) begin
         first_history_in  = {first_history_ff[HIST_W-2:0], encoder_bits[ENC1_LINE]};
         second_history_in = {second_history_ff[HIST_W-2:0], encoder_bits[ENC2_LINE]};
      end
      count_enable = is_encoder && mode_is_ok(mode_bits_ff);
      mode_ext     = $signed({{(SUM_W-MODE_W){1'b0}}, mode_bits_ff});
      step1 = '0;
      step2 = '0;
      if (count_enable && first_history_in == STEP_PATTERN) begin
         step1 = encoder_bits[ENC1_DIR] ? mode_ext : -mode_ext;
      end
      if (count_enable && second_history_in == STEP_PATTERN) begin
         step2 = encoder_bits[ENC2_DIR] ? mode_ext : -mode_ext;
      end
      sum_raw  = $signed({2'b00, counter_ff}) + step1 + step2;
      sum_wrap = (sum_raw < 0) ? sum_raw + SPAN_S : sum_raw;
      // overshoot drops to zero rather than wrapping
      counter_in = (sum_wrap > TOP_S) ? '0 : sum_wrap[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_buttons_ff   <= '0;
         stable_count_ff   <= '0;
         mode_bits_ff      <= MODE_RESET;
         first_history_ff  <= '0;
         second_history_ff <= '0;
         counter_ff        <= '0;
      end else if (accept) begin
         last_buttons_ff   <= last_buttons_in;
         stable_count_ff   <= stable_count_in;
         mode_bits_ff      <= mode_bits_in;
         first_history_ff  <= first_history_in;
         second_history_ff <= second_history_in;
         counter_ff        <= counter_in;
      end
   end

   assign status.mode_now = mode_bits_in;
   assign status.mode_ok  = mode_is_ok(mode_bits_in);
   assign count_value     = counter_in;

endmodule
`default_nettype wire

[hdl/encoder_step_counter_with_mode_keys_core.sv]
// Top level: sample stream in, mode and counter stream out, with output skid stage.
//
// Input beats carry either a pushbutton sample (req_tuser = 0) or an encoder
// sample (req_tuser = 1). Pushbutton samples are debounced; after seven equal
// samples the mode bits are toggled by the pressed buttons once. Encoder
// samples shift each encoder's line into a six-deep history; a stable high
// followed by a fresh low steps the counter by the mode, up or down by the
// direction bit, while the mode is zero or one-hot.
// Every input beat yields exactly one output beat: mode, counter, mode_ok.
// The result of an accepted beat is registered and presented on the rsp channel.
// One beat per cycle is taken while the receiver keeps up, as the combinational
// state update feeds the result register directly.
// When the receiver stalls, one further beat is taken into a skid register;
// req_tready then drops until the receiver takes a beat.
// Reset (synchronous) clears both output valid flags, sets the mode to 1 and
// clears the counter, histories and debounce state.
`default_nettype none
module encoder_step_counter_with_mode_keys_core #(
   parameter int COUNT_SPAN   = escmk_pkg::COUNT_SPAN_DEF,
   localparam int CNT_W       = $clog2(COUNT_SPAN),
   localparam int RSP_W       = escmk_pkg::MODE_W + CNT_W + 1,
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // buttons [7:0], encoder_bits [11:8], zero fill above
   input  wire logic [escmk_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // mode_now [7:0], count_value [8 +: CNT_W], mode_ok above it, zero fill above
   output logic [RSP_TDATA_W-1:0]                 rsp_tdata
);
   import escmk_pkg::*;

   logic                   accept;
   logic                   rsp_take;
   status_type             status;
   logic [CNT_W-1:0]       count_value;
   logic [RSP_TDATA_W-1:0] beat_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   logic [RSP_TDATA_W-1:0] skid_data_ff, skid_data_in;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_take   = out_valid_ff && rsp_tready;

   escmk_update #(
      .COUNT_SPAN(COUNT_SPAN)
   ) u_update (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (req_tuser),
      .buttons     (req_tdata[REQ_BTN_LSB +: BTN_W]),
      .encoder_bits(req_tdata[REQ_ENC_LSB +: ENC_W]),
      .status      (status),
      .count_value (count_value)
   );

   always_comb begin
      beat_in = '0;
      beat_in[MODE_W-1:0]     = status.mode_now;
      beat_in[MODE_W +: CNT_W] = count_value;
      beat_in[MODE_W + CNT_W] = status.mode_ok;
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // drain the skid beat first
         if (rsp_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || rsp_take) begin
            out_data_in  = beat_in;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = beat_in;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire

[hdl/escmk_checker.sv]
// Port-level checks for the encoder step counter, bound to the top level.
`default_nettype none
module escmk_checker #(
   parameter int COUNT_SPAN   = escmk_pkg::COUNT_SPAN_DEF,
   localparam int CNT_W       = $clog2(COUNT_SPAN),
   localparam int RSP_W       = escmk_pkg::MODE_W + CNT_W + 1,
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);
   import escmk_pkg::*;

   logic [MODE_W-1:0] mode_seen;
   logic [CNT_W-1:0]  count_seen;
   logic              ok_seen;

   assign mode_seen  = rsp_tdata[MODE_W-1:0];
   assign count_seen = rsp_tdata[MODE_W +: CNT_W];
   assign ok_seen    = rsp_tdata[MODE_W + CNT_W];

   // a stalled result beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // input stalls only while a result is waiting
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output");

   a_mode_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ok_seen == mode_is_ok(mode_seen))
      else $error("mode_ok disagrees with mode");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(count_seen) < 32'(COUNT_SPAN))
      else $error("counter outside its span");

endmodule

bind encoder_step_counter_with_mode_keys_core escmk_checker #(
   .COUNT_SPAN(COUNT_SPAN)
) u_escmk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
`default_nettype wire
